FILE: rtl/l3d_pkg.sv
// shared constants, types and codes for the 3d colour table mapper
`timescale 1ns / 1ps
package l3d_pkg;

  // lattice and fixed point format
  localparam int MAX_GRID    = 33;
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int GRID_W      = 6;
  localparam int SQ_W        = $clog2(MAX_GRID * MAX_GRID + 1);
  localparam int CELL_W      = $clog2(MAX_GRID - 1);
  localparam int CH_W        = FRAC_BITS + 1;
  localparam int PIX_W       = 18;
  localparam int ENTRY_W     = 3 * CH_W;
  localparam int CORNERS     = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CH_W-1:0] ONE_FX = CH_W'(1) << FRAC_BITS;

  // item codes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } op_t;

  // one item between the front and back parts
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
    logic [CH_W-1:0]   fx;
    logic [CH_W-1:0]   fy;
    logic [CH_W-1:0]   fz;
  } q_item_t;

endpackage

FILE: rtl/l3d_front.sv
// front part: takes items, splits pixel channels into cells and fractions, forms base index for pixel maps
`timescale 1ns / 1ps
module l3d_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [l3d_pkg::IDX_W-1:0]     entry_index,
  input  logic [l3d_pkg::CH_W-1:0]      entry_red,
  input  logic [l3d_pkg::CH_W-1:0]      entry_green,
  input  logic [l3d_pkg::CH_W-1:0]      entry_blue,
  input  logic signed [l3d_pkg::PIX_W-1:0] pixel_red,
  input  logic signed [l3d_pkg::PIX_W-1:0] pixel_green,
  input  logic signed [l3d_pkg::PIX_W-1:0] pixel_blue,
  input  logic [l3d_pkg::GRID_W-1:0]    grid,
  input  logic [l3d_pkg::SQ_W-1:0]      grid_sq,
  input  logic                          q_full,
  output logic                          push,
  output l3d_pkg::q_item_t              push_item
);
  import l3d_pkg::*;

  localparam int X_W = CH_W + GRID_W;

  // clamp one signed channel to [0, 1.0]
  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [PIX_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v[PIX_W-1]) r = '0;
    else if (v > $signed({1'b0, ONE_FX})) r = ONE_FX;
    else r = v[CH_W-1:0];
    return r;
  endfunction

  logic adv;

  // stage 1: clamped and scaled channels
  logic              v1;
  op_t               op1;
  logic [IDX_W-1:0]  idx1;
  logic [ENTRY_W-1:0] data1;
  logic [X_W-1:0]    x1 [3];

  // stage 2: cell index and fraction per axis
  logic              v2;
  op_t               op2;
  logic [IDX_W-1:0]  idx2;
  logic [ENTRY_W-1:0] data2;
  logic [CELL_W-1:0] cell2 [3];
  logic [CH_W-1:0]   frac2 [3];

  // stage 3: linear base index
  logic              v3;
  q_item_t           it3;

  logic [GRID_W-1:0] n_m1;
  logic [GRID_W-1:0] n_m2;
  logic [CH_W-1:0]   clamped [3];
  logic [CELL_W-1:0] cell_next [3];
  logic [CH_W-1:0]   frac_next [3];
  logic [IDX_W-1:0]  base_next;

  assign adv      = !(v3 && q_full);
  assign in_stall = v3 && q_full;
  assign push     = adv && v3;
  assign push_item = it3;

  assign n_m1 = grid - GRID_W'(1);
  assign n_m2 = grid - GRID_W'(2);

  assign clamped[0] = clamp_ch(pixel_red);
  assign clamped[1] = clamp_ch(pixel_green);
  assign clamped[2] = clamp_ch(pixel_blue);

  // cell capped at n-2, remainder as fraction
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [X_W-FRAC_BITS-1:0] raw;
      raw = x1[a][X_W-1:FRAC_BITS];
      if (raw > (X_W-FRAC_BITS)'(n_m2)) cell_next[a] = n_m2[CELL_W-1:0];
      else cell_next[a] = raw[CELL_W-1:0];
      frac_next[a] = CH_W'(x1[a] - (X_W'(cell_next[a]) << FRAC_BITS));
    end
  end

  // base = z*n*n + y*n + x
  assign base_next = IDX_W'(cell2[2] * grid_sq) + IDX_W'(cell2[1] * grid)
                   + IDX_W'(cell2[0]);

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= op_t'(operation);
      idx1  <= entry_index;
      data1 <= {entry_red, entry_green, entry_blue};
      for (int a = 0; a < 3; a++) x1[a] <= X_W'(clamped[a] * n_m1);
      op2   <= op1;
      idx2  <= idx1;
      data2 <= data1;
      cell2 <= cell_next;
      frac2 <= frac_next;
      it3.op   <= op2;
      it3.addr <= (op2 == OP_WRITE) ? idx2 : base_next;
      it3.data <= data2;
      it3.fx   <= frac2[0];
      it3.fy   <= frac2[1];
      it3.fz   <= frac2[2];
    end
  end

endmodule

FILE: rtl/l3d_queue.sv
// short queue between the front and back parts
`timescale 1ns / 1ps
module l3d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  l3d_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output l3d_pkg::q_item_t head
);
  import l3d_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_item_t            store [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_item;
  end

endmodule

FILE: rtl/l3d_back.sv
// back part: table banks, corner fetch and trilinear blend with rounding
`timescale 1ns / 1ps
module l3d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [l3d_pkg::GRID_W-1:0]  grid,
  input  logic [l3d_pkg::SQ_W-1:0]    grid_sq,
  input  logic                        empty,
  input  l3d_pkg::q_item_t            head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [l3d_pkg::CH_W-1:0]    mapped_red,
  output logic [l3d_pkg::CH_W-1:0]    mapped_green,
  output logic [l3d_pkg::CH_W-1:0]    mapped_blue
);
  import l3d_pkg::*;

  localparam int ROW_W   = 2 * FRAC_BITS + 1;
  localparam int PLANE_W = 3 * FRAC_BITS + 1;
  localparam int LO_W    = 24;
  localparam int HI_W    = PLANE_W - LO_W;
  localparam int LOS_W   = LO_W + CH_W + 1;
  localparam int HIS_W   = HI_W + CH_W + 1;
  localparam int SUM_W   = HIS_W + LO_W + 1;
  localparam int Q_W     = SUM_W - 3 * FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (3 * FRAC_BITS - 1);

  logic adv;

  // fetch stage
  logic               v0;
  logic [ENTRY_W-1:0] rd [CORNERS];
  logic [CH_W-1:0]    fx0, fy0, fz0;
  logic [IDX_W-1:0]   raddr [CORNERS];
  logic               wr_en;

  // blend stages
  logic               v1, v2, v3;
  logic [ROW_W-1:0]   row1 [3][4];
  logic [CH_W-1:0]    fy1, fz1;
  logic [PLANE_W-1:0] plane2 [3][2];
  logic [CH_W-1:0]    fz2;
  logic [LOS_W-1:0]   lo3 [3];
  logic [HIS_W-1:0]   hi3 [3];

  logic [CH_W-1:0]    mapped_next [3];

  assign adv   = !(out_valid && out_stall);
  assign pop   = adv && !empty;
  assign wr_en = pop && (head.op == OP_WRITE) && (32'(head.addr) < TABLE_DEPTH);

  // corner addresses: bit 0 steps red, bit 1 green, bit 2 blue
  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      raddr[k] = head.addr + (k[0] ? IDX_W'(1) : '0) + (k[1] ? IDX_W'(grid) : '0)
               + (k[2] ? IDX_W'(grid_sq) : '0);
    end
  end

  // one table copy per corner, all written together
  for (genvar k = 0; k < CORNERS; k++) begin : g_bank
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) mem[head.addr] <= head.data;
      if (adv)   rd[k] <= mem[raddr[k]];
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0 <= pop && (head.op == OP_MAP);
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // final sum, round half up, saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [SUM_W-1:0] total;
      logic [Q_W-1:0]   q;
      total = (SUM_W'(hi3[c]) << LO_W) + SUM_W'(lo3[c]) + HALF;
      q = total[SUM_W-1:3*FRAC_BITS];
      mapped_next[c] = (q > Q_W'(ONE_FX)) ? ONE_FX : q[CH_W-1:0];
    end
  end

  // blend datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      fx0 <= head.fx;
      fy0 <= head.fy;
      fz0 <= head.fz;
      // along red: rows indexed {blue, green}
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 4; r++) begin
          row1[c][r] <= ROW_W'(rd[2*r][ENTRY_W-1-c*CH_W -: CH_W] * (ONE_FX - fx0))
                      + ROW_W'(rd[2*r+1][ENTRY_W-1-c*CH_W -: CH_W] * fx0);
        end
      end
      fy1 <= fy0;
      fz1 <= fz0;
      // along green
      for (int c = 0; c < 3; c++) begin
        for (int z = 0; z < 2; z++) begin
          plane2[c][z] <= PLANE_W'(row1[c][2*z] * (ONE_FX - fy1))
                        + PLANE_W'(row1[c][2*z+1] * fy1);
        end
      end
      fz2 <= fz1;
      // along blue, split into low and high partial products
      for (int c = 0; c < 3; c++) begin
        lo3[c] <= LOS_W'(plane2[c][0][LO_W-1:0] * (ONE_FX - fz2))
                + LOS_W'(plane2[c][1][LO_W-1:0] * fz2);
        hi3[c] <= HIS_W'(plane2[c][0][PLANE_W-1:LO_W] * (ONE_FX - fz2))
                + HIS_W'(plane2[c][1][PLANE_W-1:LO_W] * fz2);
      end
      mapped_red   <= mapped_next[0];
      mapped_green <= mapped_next[1];
      mapped_blue  <= mapped_next[2];
    end
  end

endmodule

FILE: rtl/lut3d_trilinear_color_map_core.sv
// Trilinear 3D colour table mapper: one pixel or table write per cycle when neither side stalls.
// Throughput: one item per cycle when neither side stalls, set by the eight replicated table banks read together.
// Reset: rst clears the pipelines, the queue and sets grid size to 33; table contents
// are undefined until written and need no clearing pass.
`timescale 1ns / 1ps
module lut3d_trilinear_color_map_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [l3d_pkg::GRID_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [l3d_pkg::IDX_W-1:0]         entry_index,
  input  logic [l3d_pkg::CH_W-1:0]          entry_red,
  input  logic [l3d_pkg::CH_W-1:0]          entry_green,
  input  logic [l3d_pkg::CH_W-1:0]          entry_blue,
  input  logic signed [l3d_pkg::PIX_W-1:0]  pixel_red,
  input  logic signed [l3d_pkg::PIX_W-1:0]  pixel_green,
  input  logic signed [l3d_pkg::PIX_W-1:0]  pixel_blue,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [l3d_pkg::CH_W-1:0]          mapped_red,
  output logic [l3d_pkg::CH_W-1:0]          mapped_green,
  output logic [l3d_pkg::CH_W-1:0]          mapped_blue
);
  import l3d_pkg::*;

  logic [GRID_W-1:0] grid;
  logic [SQ_W-1:0]   grid_sq;
  logic [GRID_W-1:0] grid_next;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  q_item_t           push_item;
  q_item_t           head;

  // grid size saturated to the supported range
  always_comb begin
    if (cfg_data < GRID_W'(2)) grid_next = GRID_W'(2);
    else if (cfg_data > GRID_W'(MAX_GRID)) grid_next = GRID_W'(MAX_GRID);
    else grid_next = cfg_data;
  end

  // grid size and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      grid    <= GRID_W'(MAX_GRID);
      grid_sq <= SQ_W'(MAX_GRID * MAX_GRID);
    end else if (cfg_write) begin
      grid    <= grid_next;
      grid_sq <= SQ_W'(grid_next * grid_next);
    end
  end

  l3d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .entry_index (entry_index),
    .entry_red   (entry_red),
    .entry_green (entry_green),
    .entry_blue  (entry_blue),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .grid        (grid),
    .grid_sq     (grid_sq),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  l3d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  l3d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .grid         (grid),
    .grid_sq      (grid_sq),
    .empty        (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_red   (mapped_red),
    .mapped_green (mapped_green),
    .mapped_blue  (mapped_blue)
  );

endmodule

FILE: tb/lut3d_trilinear_color_map_core_test.sv
// testbench for the trilinear 3d colour table mapper, with scoreboard and stimulus
`timescale 1ns / 1ps
module lut3d_trilinear_color_map_core_test;
  import l3d_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int MIXED_ITEMS = 85;

  // one input transfer and one mapped pixel
  typedef struct {
    op_t                     op;
    logic [IDX_W-1:0]        index;
    logic [CH_W-1:0]         er, eg, eb;
    logic signed [PIX_W-1:0] pr, pg, pb;
  } lut_job_t;

  typedef struct {
    logic [CH_W-1:0] r, g, b;
  } rgb_t;

  typedef struct {
    int unsigned x, y, z;
  } cell_t;

  // mirror of the table and grid, plus the queue of pixels still to come out
  class colour_map_scoreboard;
    logic [CH_W-1:0] tab_red[TABLE_DEPTH];
    logic [CH_W-1:0] tab_green[TABLE_DEPTH];
    logic [CH_W-1:0] tab_blue[TABLE_DEPTH];
    int unsigned grid;
    rgb_t pending_rgb[$];
    int unsigned errors, writes_seen, maps_seen, maps_checked;

    function new();
      grid = MAX_GRID;
    endfunction

    function void set_grid(logic [GRID_W-1:0] v);
      if (v < 2) grid = 2;
      else if (v > MAX_GRID) grid = MAX_GRID;
      else grid = 32'(v);
    endfunction

    // clamp to [0,1], scale by n-1, split into cell and fraction
    static function void split_axis(logic signed [PIX_W-1:0] raw, int unsigned n,
                                    output int unsigned cell_no,
                                    output logic [CH_W-1:0] frac);
      int v;
      logic [31:0] x;
      logic [31:0] idx;
      v = raw;
      if (v < 0) v = 0;
      else if (v > int'(ONE_FX)) v = int'(ONE_FX);
      x = 32'(v) * 32'(n - 1);
      idx = x >> FRAC_BITS;
      if (idx > n - 2) idx = n - 2;
      cell_no = idx;
      frac = CH_W'(x - (idx << FRAC_BITS));
    endfunction

    function logic [79:0] entry(int c, int unsigned idx);
      case (c)
        0: entry = 80'(tab_red[idx]);
        1: entry = 80'(tab_green[idx]);
        default: entry = 80'(tab_blue[idx]);
      endcase
    endfunction

    // exact trilinear blend, one rounding, saturate to 1.0
    function rgb_t blend_pixel(lut_job_t j);
      int unsigned ix, iy, iz, base, n;
      logic [CH_W-1:0] fx, fy, fz;
      logic [79:0] unit, row[2], plane[2], acc;
      logic [CH_W-1:0] ch[3];
      rgb_t res;
      n = grid;
      unit = 80'd1 << FRAC_BITS;
      split_axis(j.pr, n, ix, fx);
      split_axis(j.pg, n, iy, fy);
      split_axis(j.pb, n, iz, fz);
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 2; k++) begin
          for (int r = 0; r < 2; r++) begin
            base = (iz + k) * n * n + (iy + r) * n + ix;
            row[r] = entry(c, base) * (unit - fx) + entry(c, base + 1) * fx;
          end
          plane[k] = row[0] * (unit - fy) + row[1] * fy;
        end
        acc = plane[0] * (unit - fz) + plane[1] * fz;
        acc = (acc + (80'd1 << (3 * FRAC_BITS - 1))) >> (3 * FRAC_BITS);
        if (acc > unit) acc = unit;
        ch[c] = acc[CH_W-1:0];
      end
      res.r = ch[0];
      res.g = ch[1];
      res.b = ch[2];
      return res;
    endfunction

    function void note_transfer(lut_job_t j);
      if (j.op == OP_WRITE) begin
        writes_seen++;
        if (j.index < TABLE_DEPTH) begin
          tab_red[j.index] = j.er;
          tab_green[j.index] = j.eg;
          tab_blue[j.index] = j.eb;
        end
      end else begin
        maps_seen++;
        pending_rgb.push_back(blend_pixel(j));
      end
    endfunction

    function void check_result(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        errors++;
        $error("unexpected mapped pixel %0d %0d %0d", r, g, b);
        return;
      end
      want = pending_rgb.pop_front();
      maps_checked++;
      if (r !== want.r) begin
        errors++;
        $error("mapped_red expected %0d actual %0d", want.r, r);
      end
      if (g !== want.g) begin
        errors++;
        $error("mapped_green expected %0d actual %0d", want.g, g);
      end
      if (b !== want.b) begin
        errors++;
        $error("mapped_blue expected %0d actual %0d", want.b, b);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [GRID_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [IDX_W-1:0] entry_index = '0;
  logic [CH_W-1:0] entry_red = '0, entry_green = '0, entry_blue = '0;
  logic signed [PIX_W-1:0] pixel_red = '0, pixel_green = '0, pixel_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] mapped_red, mapped_green, mapped_blue;

  colour_map_scoreboard sb;
  bit written[TABLE_DEPTH];
  cell_t ready_cells[$];
  int burst_left = 1;
  bit hold_req = 0;
  int grids_run = 0;

  lut3d_trilinear_color_map_core DUT (
    .clk, .rst, .cfg_write, .cfg_data,
    .in_valid, .in_stall, .operation, .entry_index,
    .entry_red, .entry_green, .entry_blue,
    .pixel_red, .pixel_green, .pixel_blue,
    .out_valid, .out_stall, .mapped_red, .mapped_green, .mapped_blue
  );

  always #5 clk = ~clk;

  // offer one item until it transfers, then keep the burst pattern going
  task automatic send_job(lut_job_t j);
    int gap;
    @(negedge clk);
    operation <= j.op;
    entry_index <= j.index;
    entry_red <= j.er;
    entry_green <= j.eg;
    entry_blue <= j.eb;
    pixel_red <= j.pr;
    pixel_green <= j.pg;
    pixel_blue <= j.pb;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(j);
    if (j.op == OP_WRITE && j.index < TABLE_DEPTH) written[j.index] = 1;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
  endtask

  function automatic logic [CH_W-1:0] rand_channel();
    if ($urandom_range(4) == 0) return CH_W'($urandom);
    return CH_W'($urandom_range(ONE_FX, 0));
  endfunction

  task automatic write_entry(int unsigned idx, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b);
    lut_job_t j;
    j.op = OP_WRITE;
    j.index = IDX_W'(idx);
    j.er = r;
    j.eg = g;
    j.eb = b;
    j.pr = PIX_W'($urandom);
    j.pg = PIX_W'($urandom);
    j.pb = PIX_W'($urandom);
    send_job(j);
  endtask

  task automatic map_rgb(logic signed [PIX_W-1:0] r, logic signed [PIX_W-1:0] g,
                         logic signed [PIX_W-1:0] b);
    lut_job_t j;
    j.op = OP_MAP;
    j.index = IDX_W'($urandom);
    j.er = CH_W'($urandom);
    j.eg = CH_W'($urandom);
    j.eb = CH_W'($urandom);
    j.pr = r;
    j.pg = g;
    j.pb = b;
    send_job(j);
  endtask

  // all eight corners of a cell must hold written entries
  function automatic bit cell_ready(int unsigned x, int unsigned y, int unsigned z,
                                    int unsigned n);
    int unsigned base;
    for (int k = 0; k < 2; k++)
      for (int r = 0; r < 2; r++) begin
        base = (z + k) * n * n + (y + r) * n + x;
        if (!written[base] || !written[base + 1]) return 0;
      end
    return 1;
  endfunction

  // a channel value that lands in the given cell, edges pushed out of range now and then
  function automatic logic signed [PIX_W-1:0] pixel_in_cell(int unsigned i, int unsigned n);
    int lo, hi;
    lo = (i * 65536 + n - 2) / (n - 1);
    hi = (i == n - 2) ? 65536 : ((i + 1) * 65536 + n - 2) / (n - 1) - 1;
    if (i == 0 && $urandom_range(5) == 0) return -PIX_W'($urandom_range(131072, 1));
    if (i == n - 2 && $urandom_range(5) == 0) return PIX_W'($urandom_range(131071, 65536));
    return PIX_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    if ($urandom_range(1) == 0) return PIX_W'($urandom);
    return PIX_W'($urandom_range(ONE_FX, 0));
  endfunction

  task automatic map_random(int unsigned n);
    logic signed [PIX_W-1:0] r, g, b;
    int unsigned cx, cy, cz;
    logic [CH_W-1:0] f;
    cell_t c;
    for (int t = 0; t < 3; t++) begin
      r = rand_pixel();
      g = rand_pixel();
      b = rand_pixel();
      colour_map_scoreboard::split_axis(r, n, cx, f);
      colour_map_scoreboard::split_axis(g, n, cy, f);
      colour_map_scoreboard::split_axis(b, n, cz, f);
      if (cell_ready(cx, cy, cz, n)) begin
        map_rgb(r, g, b);
        return;
      end
    end
    c = ready_cells[$urandom_range(ready_cells.size() - 1)];
    map_rgb(pixel_in_cell(c.x, n), pixel_in_cell(c.y, n), pixel_in_cell(c.z, n));
  endtask

  // small grids get the whole cube, large ones a few cells including both corners
  task automatic fill_cells(int unsigned n);
    cell_t c;
    ready_cells.delete();
    if (n <= 5) begin
      for (int unsigned i = 0; i < n * n * n; i++)
        write_entry(i, rand_channel(), rand_channel(), rand_channel());
      c = '{0, 0, 0};
      ready_cells.push_back(c);
      return;
    end
    for (int q = 0; q < 6; q++) begin
      if (q == 0) c = '{0, 0, 0};
      else if (q == 1) c = '{n - 2, n - 2, n - 2};
      else c = '{$urandom_range(n - 2), $urandom_range(n - 2), $urandom_range(n - 2)};
      ready_cells.push_back(c);
      for (int k = 0; k < 2; k++)
        for (int r = 0; r < 2; r++)
          for (int i = 0; i < 2; i++)
            write_entry((c.z + k) * n * n + (c.y + r) * n + c.x + i,
                        rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  // mostly pixel maps, with table rewrites and ignored writes mixed in
  task automatic mixed_run(int unsigned n, int count);
    int sel;
    repeat (count) begin
      sel = $urandom_range(9);
      if (sel == 0)
        write_entry($urandom_range(65535), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      else if (sel == 1)
        write_entry($urandom_range(n * n * n - 1), rand_channel(), rand_channel(),
                    rand_channel());
      else
        map_random(n);
    end
  endtask

  // stop offering and wait until every pixel is out and the pipe has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(logic [GRID_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_grid(v);
    grids_run++;
  endtask

  // receiver stall pattern, changing mode at random
  initial begin
    int mode, left, tick;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3);
          left = $urandom_range(80, 16);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(3) != 0);
          default: out_stall <= tick[0];
        endcase
      end
    end
  end

  // result transfers
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(mapped_red, mapped_green, mapped_blue);
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin
    int grid_plan[];
    grid_plan = '{3, 4, 5, 1, 33, 9, 63, 17, 2, 45, 6};
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: a two point grid from a zero write, extreme entries and pixels
    write_grid('0);
    write_entry(0, 0, 0, 0);
    write_entry(1, ONE_FX, ONE_FX, ONE_FX);
    write_entry(2, 17'h1FFFF, 0, ONE_FX);
    write_entry(3, ONE_FX, 17'h1FFFF, 0);
    for (int unsigned i = 4; i < 8; i++)
      write_entry(i, rand_channel(), rand_channel(), 17'h1FFFF);
    write_entry(65535, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    write_entry(TABLE_DEPTH - 1, ONE_FX, 0, ONE_FX);
    map_rgb(0, 0, 0);
    map_rgb(65536, 65536, 65536);
    map_rgb(-131072, 131071, 32768);
    map_rgb(-1, 65537, 1);
    map_rgb(131071, 131071, 131071);
    map_rgb(32768, 32768, 32768);
    map_rgb(65535, 1, 49152);
    map_rgb(rand_pixel(), rand_pixel(), rand_pixel());

    // random phases over a spread of grid sizes
    foreach (grid_plan[p]) begin
      settle();
      write_grid(GRID_W'(grid_plan[p]));
      fill_cells(sb.grid);
      if (grid_plan[p] == 63) hold_req = 1;
      mixed_run(sb.grid, MIXED_ITEMS);
    end
    settle();

    $display("run covered %0d table writes and %0d pixel maps (%0d checked)",
             sb.writes_seen, sb.maps_seen, sb.maps_checked);
    $display("over %0d grid settings including clamped register values", grids_run);
    if (sb.errors == 0 && sb.pending_rgb.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
